/* hdl/assert_macros.svh */
// Assertion macros used by the port-level checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/tri2d_pkg.sv */
// Types and widths shared by the planar trilateration pipeline.
`default_nettype none

package tri2d_pkg;

   // Field widths
   localparam int COORD_BITS = 16;
   localparam int TAG_BITS   = 16;

   // Datapath widths, all derived from the coordinate width
   localparam int SQ_W   = 2 * COORD_BITS;        // square of a coordinate or range
   localparam int A_W    = 2 * COORD_BITS + 1;    // x^2 + y^2 - d^2
   localparam int DIFF_W = COORD_BITS + 1;        // coordinate difference
   localparam int DETP_W = COORD_BITS + DIFF_W;   // coordinate times difference
   localparam int PROD_W = A_W + DIFF_W;          // A term times difference
   localparam int NUM_W  = PROD_W + 2;            // sum of three products
   localparam int DET_W  = DETP_W + 2;            // determinant
   localparam int DEN_W  = DET_W + 1;             // doubled determinant
   localparam int QUO_W  = COORD_BITS + 1;        // quotient bits kept by the divider
   localparam int QB     = $clog2(QUO_W);         // quotient bit index
   localparam int CMP_W  = DEN_W + QUO_W;         // divisor shifted by a full quotient

   // Saturation limits
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [QUO_W-1:0] LIMIT_POS = QUO_W'((1 << (COORD_BITS - 1)) - 1);
   localparam logic [QUO_W-1:0] LIMIT_NEG = QUO_W'(1 << (COORD_BITS - 1));

   // One measurement set
   typedef struct packed {
      logic signed [COORD_BITS-1:0] anchor1_x;
      logic signed [COORD_BITS-1:0] anchor1_y;
      logic        [COORD_BITS-1:0] range1;
      logic signed [COORD_BITS-1:0] anchor2_x;
      logic signed [COORD_BITS-1:0] anchor2_y;
      logic        [COORD_BITS-1:0] range2;
      logic signed [COORD_BITS-1:0] anchor3_x;
      logic signed [COORD_BITS-1:0] anchor3_y;
      logic        [COORD_BITS-1:0] range3;
      logic        [TAG_BITS-1:0]   device_tag;
   } req_type;

   // One computed position
   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic        [TAG_BITS-1:0]   tag_out;
      logic                         collinear;
      logic                         clipped;
   } rsp_type;

   // Numerators and denominator handed from the front end to the divider
   typedef struct packed {
      logic signed [NUM_W-1:0] num_x;
      logic signed [NUM_W-1:0] num_y;
      logic signed [DEN_W-1:0] den;
      logic                    collinear;
      logic [TAG_BITS-1:0]     tag;
   } sums_type;

endpackage

`default_nettype wire

/* hdl/tri2d_front.sv */
// Front end: squares, differences, products and sums up to numerators and determinant.
`default_nettype none

module tri2d_front
   import tri2d_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_stall,
   input  wire req_type  in_data,
   output logic          out_valid,
   input  wire logic     out_stall,
   output sums_type      out_data
);

   localparam int NS = 4;

   // Stage 1: squares and differences
   typedef struct packed {
      logic [SQ_W-1:0] xsq1, ysq1, dsq1;
      logic [SQ_W-1:0] xsq2, ysq2, dsq2;
      logic [SQ_W-1:0] xsq3, ysq3, dsq3;
      logic signed [COORD_BITS-1:0] x1, x2, x3;
      logic signed [DIFF_W-1:0] dx32, dx13, dx21;
      logic signed [DIFF_W-1:0] dy32, dy13, dy21;
      logic [TAG_BITS-1:0] tag;
   } f1_type;

   // Stage 2: A terms and determinant products
   typedef struct packed {
      logic signed [A_W-1:0] a1, a2, a3;
      logic signed [DIFF_W-1:0] dx32, dx13, dx21;
      logic signed [DIFF_W-1:0] dy32, dy13, dy21;
      logic signed [DETP_W-1:0] detp1, detp2, detp3;
      logic [TAG_BITS-1:0] tag;
   } f2_type;

   // Stage 3: numerator products and determinant
   typedef struct packed {
      logic signed [PROD_W-1:0] px1, px2, px3;
      logic signed [PROD_W-1:0] py1, py2, py3;
      logic signed [DET_W-1:0] det;
      logic [TAG_BITS-1:0] tag;
   } f3_type;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS:0]   ready;

   f1_type   s1_ff, s1_in;
   f2_type   s2_ff, s2_in;
   f3_type   s3_ff, s3_in;
   sums_type s4_ff, s4_in;

   // Stage advances when empty or when the next one moves
   assign ready[NS] = !out_stall;
   for (genvar i = 0; i < NS; i++) begin : g_ready
      assign ready[i] = !v_ff[i] || ready[i+1];
   end

   assign v_in      = {v_ff[NS-2:0], in_valid};
   assign in_stall  = !ready[0];
   assign out_valid = v_ff[NS-1];
   assign out_data  = s4_ff;

   // Squares of coordinates and ranges, pairwise differences
   always_comb begin
      s1_in.xsq1 = SQ_W'(SQ_W'(in_data.anchor1_x) * SQ_W'(in_data.anchor1_x));
      s1_in.ysq1 = SQ_W'(SQ_W'(in_data.anchor1_y) * SQ_W'(in_data.anchor1_y));
      s1_in.dsq1 = SQ_W'(in_data.range1) * SQ_W'(in_data.range1);
      s1_in.xsq2 = SQ_W'(SQ_W'(in_data.anchor2_x) * SQ_W'(in_data.anchor2_x));
      s1_in.ysq2 = SQ_W'(SQ_W'(in_data.anchor2_y) * SQ_W'(in_data.anchor2_y));
      s1_in.dsq2 = SQ_W'(in_data.range2) * SQ_W'(in_data.range2);
      s1_in.xsq3 = SQ_W'(SQ_W'(in_data.anchor3_x) * SQ_W'(in_data.anchor3_x));
      s1_in.ysq3 = SQ_W'(SQ_W'(in_data.anchor3_y) * SQ_W'(in_data.anchor3_y));
      s1_in.dsq3 = SQ_W'(in_data.range3) * SQ_W'(in_data.range3);
      s1_in.x1   = in_data.anchor1_x;
      s1_in.x2   = in_data.anchor2_x;
      s1_in.x3   = in_data.anchor3_x;
      s1_in.dx32 = DIFF_W'(in_data.anchor3_x) - DIFF_W'(in_data.anchor2_x);
      s1_in.dx13 = DIFF_W'(in_data.anchor1_x) - DIFF_W'(in_data.anchor3_x);
      s1_in.dx21 = DIFF_W'(in_data.anchor2_x) - DIFF_W'(in_data.anchor1_x);
      s1_in.dy32 = DIFF_W'(in_data.anchor3_y) - DIFF_W'(in_data.anchor2_y);
      s1_in.dy13 = DIFF_W'(in_data.anchor1_y) - DIFF_W'(in_data.anchor3_y);
      s1_in.dy21 = DIFF_W'(in_data.anchor2_y) - DIFF_W'(in_data.anchor1_y);
      s1_in.tag  = in_data.device_tag;
   end

   // A = x^2 + y^2 - d^2 per anchor; x times y differences for the determinant
   always_comb begin
      s2_in.a1 = $signed({1'b0, s1_ff.xsq1}) + $signed({1'b0, s1_ff.ysq1})
               - $signed({1'b0, s1_ff.dsq1});
      s2_in.a2 = $signed({1'b0, s1_ff.xsq2}) + $signed({1'b0, s1_ff.ysq2})
               - $signed({1'b0, s1_ff.dsq2});
      s2_in.a3 = $signed({1'b0, s1_ff.xsq3}) + $signed({1'b0, s1_ff.ysq3})
               - $signed({1'b0, s1_ff.dsq3});
      s2_in.dx32  = s1_ff.dx32;
      s2_in.dx13  = s1_ff.dx13;
      s2_in.dx21  = s1_ff.dx21;
      s2_in.dy32  = s1_ff.dy32;
      s2_in.dy13  = s1_ff.dy13;
      s2_in.dy21  = s1_ff.dy21;
      s2_in.detp1 = DETP_W'(s1_ff.x1) * DETP_W'(s1_ff.dy32);
      s2_in.detp2 = DETP_W'(s1_ff.x2) * DETP_W'(s1_ff.dy13);
      s2_in.detp3 = DETP_W'(s1_ff.x3) * DETP_W'(s1_ff.dy21);
      s2_in.tag   = s1_ff.tag;
   end

   // Cross products of A terms with differences; determinant sum
   always_comb begin
      s3_in.px1 = PROD_W'(s2_ff.a1) * PROD_W'(s2_ff.dy32);
      s3_in.px2 = PROD_W'(s2_ff.a2) * PROD_W'(s2_ff.dy13);
      s3_in.px3 = PROD_W'(s2_ff.a3) * PROD_W'(s2_ff.dy21);
      s3_in.py1 = PROD_W'(s2_ff.a1) * PROD_W'(s2_ff.dx32);
      s3_in.py2 = PROD_W'(s2_ff.a2) * PROD_W'(s2_ff.dx13);
      s3_in.py3 = PROD_W'(s2_ff.a3) * PROD_W'(s2_ff.dx21);
      s3_in.det = DET_W'(s2_ff.detp1) + DET_W'(s2_ff.detp2) + DET_W'(s2_ff.detp3);
      s3_in.tag = s2_ff.tag;
   end

   // Numerator sums; the y denominator is the negated x denominator
   always_comb begin
      s4_in.num_x     = NUM_W'(s3_ff.px1) + NUM_W'(s3_ff.px2) + NUM_W'(s3_ff.px3);
      s4_in.num_y     = NUM_W'(s3_ff.py1) + NUM_W'(s3_ff.py2) + NUM_W'(s3_ff.py3);
      s4_in.den       = $signed({s3_ff.det, 1'b0});
      s4_in.collinear = (s3_ff.det == '0);
      s4_in.tag       = s3_ff.tag;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (ready[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s1_ff <= s1_in;
      end
      if (ready[1]) begin
         s2_ff <= s2_in;
      end
      if (ready[2]) begin
         s3_ff <= s3_in;
      end
      if (ready[3]) begin
         s4_ff <= s4_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/tri2d_div.sv */
// Pipelined restoring divider for both coordinates, with saturation and result register.
`default_nettype none

module tri2d_div
   import tri2d_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_stall,
   input  wire sums_type in_data,
   output logic          out_valid,
   input  wire logic     out_stall,
   output rsp_type       out_data
);

   // Magnitude stage, overflow stage, one stage per quotient bit, result stage
   localparam int NST = QUO_W + 2;
   localparam int NS  = NST + 1;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] q;
      logic             neg;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      lane_type            lx;
      lane_type            ly;
      logic [DEN_W-1:0]    dmag;
      logic                collinear;
      logic [TAG_BITS-1:0] tag;
   } stage_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos;
      logic                         clip;
   } coord_type;

   // One restoring step: try to subtract the divisor shifted to bit k
   function automatic lane_type div_step(lane_type l, logic [DEN_W-1:0] d,
                                         logic [QB-1:0] k);
      logic [CMP_W-1:0] rem_w;
      logic [CMP_W-1:0] sub;
      lane_type         r;
      r     = l;
      rem_w = CMP_W'(l.rem);
      sub   = CMP_W'(d) << k;
      if (rem_w >= sub) begin
         r.rem  = NUM_W'(rem_w - sub);
         r.q[k] = 1'b1;
      end
      return r;
   endfunction

   // Apply sign and clamp to the coordinate range
   function automatic coord_type saturate(lane_type l);
      logic [QUO_W-1:0] lim;
      coord_type        r;
      lim = l.neg ? LIMIT_NEG : LIMIT_POS;
      if (l.ovf || (l.q > lim)) begin
         r.pos  = l.neg ? COORD_MIN : COORD_MAX;
         r.clip = 1'b1;
      end else begin
         r.pos  = l.neg ? COORD_BITS'(-l.q) : COORD_BITS'(l.q);
         r.clip = 1'b0;
      end
      return r;
   endfunction

   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS:0]   ready;

   stage_type st_ff [NST];
   stage_type mag_in;
   stage_type ovf_in;
   stage_type step_in [QUO_W];
   rsp_type   rsp_ff, rsp_in;
   coord_type cx, cy;

   // Stage advances when empty or when the next one moves
   assign ready[NS] = !out_stall;
   for (genvar i = 0; i < NS; i++) begin : g_ready
      assign ready[i] = !v_ff[i] || ready[i+1];
   end

   assign v_in      = {v_ff[NS-2:0], in_valid};
   assign in_stall  = !ready[0];
   assign out_valid = v_ff[NS-1];
   assign out_data  = rsp_ff;

   // Magnitudes and quotient signs; den_y is -den_x, so its sign is inverted
   always_comb begin
      mag_in.lx.rem    = in_data.num_x[NUM_W-1] ? NUM_W'(-in_data.num_x)
                                                : NUM_W'(in_data.num_x);
      mag_in.ly.rem    = in_data.num_y[NUM_W-1] ? NUM_W'(-in_data.num_y)
                                                : NUM_W'(in_data.num_y);
      mag_in.lx.q      = '0;
      mag_in.ly.q      = '0;
      mag_in.lx.neg    = in_data.num_x[NUM_W-1] ^ in_data.den[DEN_W-1];
      mag_in.ly.neg    = in_data.num_y[NUM_W-1] ^ ~in_data.den[DEN_W-1];
      mag_in.lx.ovf    = 1'b0;
      mag_in.ly.ovf    = 1'b0;
      mag_in.dmag      = in_data.den[DEN_W-1] ? DEN_W'(-in_data.den)
                                              : DEN_W'(in_data.den);
      mag_in.collinear = in_data.collinear;
      mag_in.tag       = in_data.tag;
   end

   // Quotient too wide for the kept bits: flag as overflow
   always_comb begin
      ovf_in        = st_ff[0];
      ovf_in.lx.ovf = CMP_W'(st_ff[0].lx.rem) >= (CMP_W'(st_ff[0].dmag) << QUO_W);
      ovf_in.ly.ovf = CMP_W'(st_ff[0].ly.rem) >= (CMP_W'(st_ff[0].dmag) << QUO_W);
   end

   // Quotient bits, most significant first, one per stage
   always_comb begin
      for (int i = 0; i < QUO_W; i++) begin
         step_in[i]    = st_ff[i+1];
         step_in[i].lx = div_step(st_ff[i+1].lx, st_ff[i+1].dmag, QB'(QUO_W - 1 - i));
         step_in[i].ly = div_step(st_ff[i+1].ly, st_ff[i+1].dmag, QB'(QUO_W - 1 - i));
      end
   end

   // Result formatting; collinear anchors give zero position
   always_comb begin
      cx = saturate(st_ff[NST-1].lx);
      cy = saturate(st_ff[NST-1].ly);
      rsp_in.tag_out   = st_ff[NST-1].tag;
      rsp_in.collinear = st_ff[NST-1].collinear;
      if (st_ff[NST-1].collinear) begin
         rsp_in.pos_x   = '0;
         rsp_in.pos_y   = '0;
         rsp_in.clipped = 1'b0;
      end else begin
         rsp_in.pos_x   = cx.pos;
         rsp_in.pos_y   = cy.pos;
         rsp_in.clipped = cx.clip || cy.clip;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (ready[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         st_ff[0] <= mag_in;
      end
      if (ready[1]) begin
         st_ff[1] <= ovf_in;
      end
      for (int i = 0; i < QUO_W; i++) begin
         if (ready[i+2]) begin
            st_ff[i+2] <= step_in[i];
         end
      end
      if (ready[NS-1]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/trilateration_2d.sv */
// Top level of the planar trilateration pipeline.
// Locates a device from three anchor positions and the measured range to each, in
// fixed point with 4 fraction bits: coordinates signed, ranges unsigned. A new
// measurement set can be taken every cycle while req_stall is low; each result passes
// through 4 front-end stages of squares, products and sums, then 20 divider stages:
// magnitude, overflow check, one stage per quotient bit over 17 bits, and the result
// register. Each pipeline stage carries its own valid bit, so a stalled output only
// holds back stages that are full and empty slots still fill. Quotients truncate toward
// zero and saturate to 16 bits, setting clipped; collinear anchors give a zero position
// with collinear set. The device tag passes through unchanged.
`default_nettype none

module trilateration_2d
   import tri2d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp
);

   logic     sums_valid;
   logic     sums_stall;
   sums_type sums;

   // Squares, differences, cross products, numerators and determinant
   tri2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req),
      .out_valid (sums_valid),
      .out_stall (sums_stall),
      .out_data  (sums)
   );

   // Division, saturation and output register
   tri2d_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sums_valid),
      .in_stall  (sums_stall),
      .in_data   (sums),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp)
   );

endmodule

`default_nettype wire

/* hdl/tri2d_checker.sv */
// Port-level assertions for the trilateration pipeline, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module tri2d_checker
   import tri2d_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic       rsp_wait;
   logic       coll_rsp;
   logic       clip_rsp;
   logic       pos_zero;
   logic       at_limit;
   logic [5:0] inflight_ff, inflight_in;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // Result conditions watched by the assertions
   assign rsp_wait = rsp_valid && rsp_stall;
   assign coll_rsp = rsp_valid && rsp.collinear;
   assign clip_rsp = rsp_valid && rsp.clipped;
   assign pos_zero = rsp.pos_x == '0 && rsp.pos_y == '0 && !rsp.clipped;
   assign at_limit = rsp.pos_x == COORD_MAX || rsp.pos_x == COORD_MIN
                  || rsp.pos_y == COORD_MAX || rsp.pos_y == COORD_MIN;

   // Items transferred in and not yet delivered
   always_comb begin
      inflight_in = inflight_ff;
      if (req_xfer && !rsp_xfer) begin
         inflight_in = inflight_ff + 6'd1;
      end else if (rsp_xfer && !req_xfer) begin
         inflight_in = inflight_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp), "held result changed")
   `ASSERT_IMPLY(a_no_orphan, clock, reset, rsp_valid, inflight_ff != '0, "orphan result")
   `ASSERT_IMPLY(a_collinear_zero, clock, reset, coll_rsp, pos_zero, "collinear result not zero")
   `ASSERT_IMPLY(a_clip_limit, clock, reset, clip_rsp, at_limit, "clipped without a limit value")

endmodule

bind trilateration_2d tri2d_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

`default_nettype wire

/* tb/trilateration_2d_checker.sv */
// Checker for the trilateration pipeline: predicts each position and compares results.
`timescale 1ns / 100ps

module trilateration_2d_checker
   import tri2d_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp,
   output int           mismatches,
   output int           outstanding
);

   // Positions predicted for accepted measurement sets, oldest first
   rsp_type pending_positions[$];
   int      fail_count = 0;

   assign mismatches = fail_count;

   // Saturate a quotient to the signed coordinate range
   function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint q,
                                                                inout logic clip);
      if (q > longint'(COORD_MAX)) begin
         clip = 1'b1;
         return COORD_MAX;
      end
      if (q < longint'(COORD_MIN)) begin
         clip = 1'b1;
         return COORD_MIN;
      end
      return COORD_BITS'(q);
   endfunction

   // Closed-form position from three anchors; every term fits in 64 bits
   function automatic rsp_type locate_device(input req_type m);
      longint  x1, y1, d1, x2, y2, d2, x3, y3, d3;
      longint  a1, a2, a3, dx32, dx13, dx21, dy32, dy13, dy21;
      longint  den_x, den_y, num_x, num_y;
      logic    clip;
      rsp_type r;
      x1 = m.anchor1_x;
      y1 = m.anchor1_y;
      d1 = m.range1;
      x2 = m.anchor2_x;
      y2 = m.anchor2_y;
      d2 = m.range2;
      x3 = m.anchor3_x;
      y3 = m.anchor3_y;
      d3 = m.range3;
      a1 = x1 * x1 + y1 * y1 - d1 * d1;
      a2 = x2 * x2 + y2 * y2 - d2 * d2;
      a3 = x3 * x3 + y3 * y3 - d3 * d3;
      dx32 = x3 - x2;
      dx13 = x1 - x3;
      dx21 = x2 - x1;
      dy32 = y3 - y2;
      dy13 = y1 - y3;
      dy21 = y2 - y1;
      den_x = 2 * (x1 * dy32 + x2 * dy13 + x3 * dy21);
      den_y = 2 * (y1 * dx32 + y2 * dx13 + y3 * dx21);
      num_x = a1 * dy32 + a2 * dy13 + a3 * dy21;
      num_y = a1 * dx32 + a2 * dx13 + a3 * dx21;
      r = '0;
      clip = 1'b0;
      r.tag_out = m.device_tag;
      // Collinear anchors: zero position, flag set
      if (den_x == 0 || den_y == 0) begin
         r.collinear = 1'b1;
      end else begin
         // Integer division truncates toward zero
         r.pos_x = clamp_coord(num_x / den_x, clip);
         r.pos_y = clamp_coord(num_y / den_y, clip);
         r.clipped = clip;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Track transfers on both channels
   always @(posedge clock) begin : track
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_positions.push_back(locate_device(req));
         if (rsp_valid && !rsp_stall) begin
            if (pending_positions.size() == 0) begin
               $error("result with no measurement set waiting, tag_out %0d", rsp.tag_out);
               fail_count++;
            end else begin
               want = pending_positions.pop_front();
               check_field("pos_x", want.pos_x, rsp.pos_x);
               check_field("pos_y", want.pos_y, rsp.pos_y);
               check_field("tag_out", want.tag_out, rsp.tag_out);
               check_field("collinear", want.collinear, rsp.collinear);
               check_field("clipped", want.clipped, rsp.clipped);
            end
         end
      end
      outstanding <= pending_positions.size();
   end

endmodule

/* tb/trilateration_2d_tb.sv */
// Testbench top for the trilateration pipeline: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module trilateration_2d_tb;
   import tri2d_pkg::*;

   localparam int RANDOM_SETS  = 1350;
   localparam int CALM_SETS    = 250;     // final stretch with no idling
   localparam int HOLD_AT      = 500;     // set index where the long output hold-off starts
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   int mismatches;
   int outstanding;
   int cycle_count = 0;
   bit hold_off_req = 1'b0;
   bit calm = 1'b0;

   trilateration_2d u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

   trilateration_2d_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run-length guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("trilateration_2d regression: fail");
         $finish;
      end
   end

   function automatic req_type make_set(input int x1, y1, r1, x2, y2, r2,
                                        x3, y3, r3, tag);
      req_type s;
      s.anchor1_x  = COORD_BITS'(x1);
      s.anchor1_y  = COORD_BITS'(y1);
      s.range1     = COORD_BITS'(r1);
      s.anchor2_x  = COORD_BITS'(x2);
      s.anchor2_y  = COORD_BITS'(y2);
      s.range2     = COORD_BITS'(r2);
      s.anchor3_x  = COORD_BITS'(x3);
      s.anchor3_y  = COORD_BITS'(y3);
      s.range3     = COORD_BITS'(r3);
      s.device_tag = TAG_BITS'(tag);
      return s;
   endfunction

   // Signed value in [-span, span]
   function automatic int spread(input int span);
      int v;
      v = $urandom_range(0, 2 * span);
      return v - span;
   endfunction

   // Measured range from an anchor to the device, with a little noise
   function automatic int range_to(input int ax, ay, px, py);
      real dx, dy;
      int  noise, r;
      dx = ax - px;
      dy = ay - py;
      noise = $urandom_range(0, 4);
      r = $rtoi($sqrt(dx * dx + dy * dy)) + noise - 2;
      if (r < 0) r = 0;
      if (r > 65535) r = 65535;
      return r;
   endfunction

   function automatic int edge_value();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 0;
         3: return 16'hffff;
         4: return 1;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // Mostly consistent geometry, plus collinear, small, edge and raw sets
   function automatic req_type random_set();
      int      kind, span, px, py, bx, by, sx, sy, k2, k3;
      int      ax[3], ay[3];
      req_type s;
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
         case ($urandom_range(0, 2))
            0: span = 200;
            1: span = 2000;
            default: span = 12000;
         endcase
         px = spread(span);
         py = spread(span);
         for (int i = 0; i < 3; i++) begin
            ax[i] = spread(span);
            ay[i] = spread(span);
         end
         s = make_set(ax[0], ay[0], range_to(ax[0], ay[0], px, py),
                      ax[1], ay[1], range_to(ax[1], ay[1], px, py),
                      ax[2], ay[2], range_to(ax[2], ay[2], px, py),
                      $urandom_range(0, 65535));
      end else if (kind == 5) begin
         // Anchors on one line
         bx = spread(1000);
         by = spread(1000);
         sx = spread(100);
         sy = spread(100);
         k2 = spread(50);
         k3 = spread(50);
         s = make_set(bx, by, $urandom_range(0, 65535),
                      bx + k2 * sx, by + k2 * sy, $urandom_range(0, 65535),
                      bx + k3 * sx, by + k3 * sy, $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
      end else if (kind == 6) begin
         s = make_set(spread(64), spread(64), $urandom_range(0, 127),
                      spread(64), spread(64), $urandom_range(0, 127),
                      spread(64), spread(64), $urandom_range(0, 127),
                      $urandom_range(0, 65535));
      end else if (kind == 7) begin
         s = make_set(edge_value(), edge_value(), edge_value(), edge_value(),
                      edge_value(), edge_value(), edge_value(), edge_value(),
                      edge_value(), edge_value());
      end else begin
         s = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      end
      return s;
   endfunction

   // Offer one set, hold it until the transfer, then maybe go idle
   task automatic send_set(input req_type item);
      int gap;
      req <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Output side: random stall bursts and one long hold-off
   initial begin
      int gap;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Collinear: all anchors at the origin, on a diagonal, on a long horizontal line
      send_set(make_set(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_set(make_set(16, 16, 10, 32, 32, 20, -48, -48, 30, 1));
      send_set(make_set(-32768, 5, 0, 0, 5, 0, 32767, 5, 0, 2));
      // Ordinary geometry
      send_set(make_set(48, 0, 48, -48, 0, 48, 0, 48, 48, 3));
      send_set(make_set(0, 0, 50, 64, 0, 52, 0, 64, 41, 4));
      // Anchors at the corners of the coordinate range
      send_set(make_set(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0, 65535));
      send_set(make_set(-32768, -32768, 65535, 32767, -32768, 65535,
                        -32768, 32767, 65535, 16'h5a5a));
      send_set(make_set(32767, 32767, 65535, -32768, 32767, 65535,
                        32767, -32768, 65535, 16'ha5a5));
      // Tiny triangle with one huge range: quotient saturates
      send_set(make_set(0, 0, 65535, 1, 0, 0, 0, 1, 0, 5));
      send_set(make_set(0, 0, 0, 1, 0, 65535, 0, 1, 0, 6));
      send_set(make_set(0, 0, 0, 1, 0, 0, 0, 1, 65535, 7));
      // Small values where truncation toward zero matters
      send_set(make_set(0, 0, 3, 3, 0, 1, 0, 3, 2, 8));
      send_set(make_set(-5, -7, 9, 11, -3, 6, 2, 13, 10, 9));
      send_set(make_set(100, -200, 65535, -300, 400, 0, 500, 600, 12345, 10));
      send_set(make_set(-1, -1, 1, 1, -1, 1, -1, 1, 1, 11));

      for (n = 0; n < RANDOM_SETS; n++) begin
         if (n == HOLD_AT) hold_off_req = 1'b1;
         if (n == RANDOM_SETS - CALM_SETS) calm = 1'b1;
         send_set(random_set());
      end
      req_valid <= 1'b0;

      // Drain, then allow for any stray results
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("trilateration_2d regression: pass");
      else
         $display("trilateration_2d regression: fail");
      $finish;
   end

endmodule
